>>> design/assert_macros.svh
// Assertion macros used by the tfcsa controller.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TFCSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfcsa assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TFCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfcsa assertion failed");

`endif

>>> design/tfcsa_pkg.sv
// Package for the template-fit chi-square accumulator: widths, codes and
// the command and status structs between controller and datapath. No dependencies.
package tfcsa_pkg;

  localparam int OBS_W     = 32;  // observed count, unsigned Q24.8
  localparam int BIN_W     = 32;  // background and templates, signed Q24.8
  localparam int SCALE_W   = 20;  // scale factors, unsigned Q4.16
  localparam int SUM_W     = 64;  // running sum, unsigned Q48.16
  localparam int PROD_W    = 53;  // signed template times unsigned scale
  localparam int OB_W      = 34;  // observed minus background, signed
  localparam int DIFF_W    = 55;  // observed minus expected, signed
  localparam int MAG_W     = 54;  // magnitude of the difference
  localparam int HALF_W    = MAG_W / 2;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int DIV_STEPS = SUM_W / 2;  // radix-4 quotient digits
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [APB_AW-1:0] REG_SCALE_FIRST  = 3'h0;
  localparam logic [APB_AW-1:0] REG_SCALE_SECOND = 3'h4;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 20'h10000;

  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HH = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_MID  = 2'd2,
    ACC_HIGH = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic     load;
    logic     prod;
    logic     diff;
    logic     mag;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_init;
    logic     div_step;
    logic     acc;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_obs_zero;
    logic last;
    logic sq_ovf;
  } dp_stat_t;

endpackage

>>> design/tfcsa_regs.sv
// APB-style configuration registers holding the two template scale factors.
// Depends on tfcsa_pkg.
module tfcsa_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tfcsa_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [tfcsa_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [tfcsa_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output logic [tfcsa_pkg::SCALE_W-1:0] scale_first,
  output logic [tfcsa_pkg::SCALE_W-1:0] scale_second
);
  import tfcsa_pkg::*;

  logic [SCALE_W-1:0] scale_first_r, scale_first_nxt;
  logic [SCALE_W-1:0] scale_second_r, scale_second_nxt;
  logic               wr_en;
  logic               sel_second;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  // Registers sit on word boundaries; the byte offset bits are ignored.
  assign sel_second = cfg_paddr[2] == REG_SCALE_SECOND[2];

  always_comb begin
    scale_first_nxt  = scale_first_r;
    scale_second_nxt = scale_second_r;
    if (wr_en) begin
      if (sel_second) begin
        scale_second_nxt = cfg_pwdata[SCALE_W-1:0];
      end else begin
        scale_first_nxt = cfg_pwdata[SCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_first_r  <= SCALE_RESET;
      scale_second_r <= SCALE_RESET;
    end else begin
      scale_first_r  <= scale_first_nxt;
      scale_second_r <= scale_second_nxt;
    end
  end

  assign cfg_prdata   = sel_second ? APB_DW'(scale_second_r) : APB_DW'(scale_first_r);
  assign scale_first  = scale_first_r;
  assign scale_second = scale_second_r;

endmodule

>>> design/tfcsa_dpath.sv
// Datapath: expected value, difference, squaring on one shared multiplier,
// radix-4 divider and saturating sum. Depends on tfcsa_pkg.
module tfcsa_dpath #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tfcsa_pkg::SCALE_W-1:0] scale_first,
  input  logic [tfcsa_pkg::SCALE_W-1:0] scale_second,
  input  logic [tfcsa_pkg::OBS_W-1:0]   in_observed_count,
  input  logic signed [tfcsa_pkg::BIN_W-1:0] in_fixed_background,
  input  logic signed [tfcsa_pkg::BIN_W-1:0] in_first_template,
  input  logic signed [tfcsa_pkg::BIN_W-1:0] in_second_template,
  input  logic                          in_last_bin,
  input  tfcsa_pkg::dp_cmd_t            cmd,
  output tfcsa_pkg::dp_stat_t           stat,
  output logic [tfcsa_pkg::SUM_W-1:0]   out_chi_square_sum,
  output logic                          out_saturated
);
  import tfcsa_pkg::*;

  localparam int SH   = FRAC_BITS + 16;   // fraction bits of the difference
  localparam int DV_W = OBS_W + SH;       // divisor is the count scaled by 2^SH
  localparam int R_W  = DV_W + 2;

  // Captured bin.
  logic [OBS_W-1:0]         obs_r;
  logic signed [BIN_W-1:0]  bg_r, t1_r, t2_r;
  logic                     last_r;

  // Expected value and difference.
  logic signed [PROD_W-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic signed [SCALE_W:0]  s1_ext, s2_ext;
  logic signed [OB_W-1:0]   ob_r, ob_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt, ob_ext, p1_ext, p2_ext, diff_neg;
  logic [MAG_W-1:0]         mag_r;

  // Squaring.
  logic [HALF_W-1:0]        mag_lo, mag_hi, mul_a, mul_b;
  logic [MAG_W-1:0]         prod_r;
  logic [SQ_W-1:0]          sq_r, sq_nxt;

  // Division.
  logic [DV_W-1:0]          dv;
  logic [R_W-1:0]           dv1, dv2, dv3_r, trial, sub;
  logic [DV_W-1:0]          rem_r;
  logic [SUM_W-1:0]         nlo_r;
  logic [1:0]               digit;
  logic                     term_sat_r;
  logic [SQ_W-SUM_W-1:0]    n_hi;

  // Sum.
  logic [SUM_W-1:0]         sum_r, sum_nxt, term, out_sum_r;
  logic                     ovf_r, ovf_nxt, out_sat_r;
  logic [SUM_W:0]           sum_wide;

  // Each template product is a signed 32 by 21 bit multiply; the wider
  // result keeps it exact.
  assign s1_ext = {1'b0, scale_first};
  assign s2_ext = {1'b0, scale_second};
  assign p1_nxt = t1_r * s1_ext;
  assign p2_nxt = t2_r * s2_ext;
  assign ob_nxt = $signed({2'b00, obs_r}) - $signed({{2{bg_r[BIN_W-1]}}, bg_r});

  assign ob_ext   = {{(DIFF_W-OB_W-16){ob_r[OB_W-1]}}, ob_r, 16'd0};
  assign p1_ext   = {{(DIFF_W-PROD_W){p1_r[PROD_W-1]}}, p1_r};
  assign p2_ext   = {{(DIFF_W-PROD_W){p2_r[PROD_W-1]}}, p2_r};
  assign diff_nxt = ob_ext - p1_ext - p2_ext;
  assign diff_neg = -diff_r;

  assign mag_lo = mag_r[HALF_W-1:0];
  assign mag_hi = mag_r[MAG_W-1:HALF_W];

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_LL: begin
        mul_a = mag_lo;
        mul_b = mag_lo;
      end
      MUL_LH: begin
        mul_a = mag_lo;
        mul_b = mag_hi;
      end
      MUL_HH: begin
        mul_a = mag_hi;
        mul_b = mag_hi;
      end
      default: begin
        mul_a = mag_lo;
        mul_b = mag_lo;
      end
    endcase
  end

  // The cross product appears twice, hence one extra bit of shift.
  always_comb begin
    unique case (cmd.acc_op)
      ACC_NONE: sq_nxt = sq_r;
      ACC_LOAD: sq_nxt = SQ_W'(prod_r);
      ACC_MID:  sq_nxt = sq_r + (SQ_W'(prod_r) << (HALF_W + 1));
      ACC_HIGH: sq_nxt = sq_r + (SQ_W'(prod_r) << (2 * HALF_W));
      default:  sq_nxt = sq_r;
    endcase
  end

  // The quotient overflows 64 bits exactly when the upper dividend part
  // reaches the divisor.
  assign dv    = {obs_r, {SH{1'b0}}};
  assign n_hi  = sq_r[SQ_W-1:SUM_W];
  assign dv1   = {2'b00, dv};
  assign dv2   = {1'b0, dv, 1'b0};
  assign trial = {rem_r, nlo_r[SUM_W-1:SUM_W-2]};

  always_comb begin
    priority if (trial >= dv3_r) begin
      digit = 2'd3;
      sub   = dv3_r;
    end else if (trial >= dv2) begin
      digit = 2'd2;
      sub   = dv2;
    end else if (trial >= dv1) begin
      digit = 2'd1;
      sub   = dv1;
    end else begin
      digit = 2'd0;
      sub   = '0;
    end
  end

  assign term     = term_sat_r ? {SUM_W{1'b1}} : nlo_r;
  assign sum_wide = {1'b0, sum_r} + {1'b0, term};

  always_comb begin
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    if (cmd.acc) begin
      sum_nxt = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      ovf_nxt = ovf_r | sum_wide[SUM_W] | term_sat_r;
    end else if (cmd.emit) begin
      sum_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obs_r  <= in_observed_count;
      bg_r   <= in_fixed_background;
      t1_r   <= in_first_template;
      t2_r   <= in_second_template;
      last_r <= in_last_bin;
    end
    if (cmd.prod) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      ob_r <= ob_nxt;
    end
    if (cmd.diff) begin
      diff_r <= diff_nxt;
    end
    if (cmd.mag) begin
      mag_r <= diff_r[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff_r[MAG_W-1:0];
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    sq_r <= sq_nxt;
    if (cmd.div_init) begin
      dv3_r      <= dv1 + dv2;
      rem_r      <= DV_W'(n_hi);
      nlo_r      <= sq_r[SUM_W-1:0];
      term_sat_r <= stat.sq_ovf;
    end else if (cmd.div_step) begin
      rem_r <= DV_W'(trial - sub);
      nlo_r <= {nlo_r[SUM_W-3:0], digit};
    end
    if (cmd.emit) begin
      out_sum_r <= sum_r;
      out_sat_r <= ovf_r;
    end
  end

  assign stat.in_obs_zero = in_observed_count == '0;
  assign stat.last        = last_r;
  assign stat.sq_ovf      = DV_W'(n_hi) >= dv;

  assign out_chi_square_sum = out_sum_r;
  assign out_saturated      = out_sat_r;

endmodule

>>> design/tfcsa_ctrl.sv
// Controller state machine: handshakes, step sequencing and divider count.
// Depends on tfcsa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tfcsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tfcsa_pkg::dp_stat_t stat,
  output tfcsa_pkg::dp_cmd_t  cmd
);
  import tfcsa_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_PROD = 12'b000000000010,
    ST_DIFF = 12'b000000000100,
    ST_MAG  = 12'b000000001000,
    ST_SQ0  = 12'b000000010000,
    ST_SQ1  = 12'b000000100000,
    ST_SQ2  = 12'b000001000000,
    ST_SQ3  = 12'b000010000000,
    ST_CHK  = 12'b000100000000,
    ST_DIV  = 12'b001000000000,
    ST_ACC  = 12'b010000000000,
    ST_FIN  = 12'b100000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             div_last;

  assign div_last = cnt_r == CNT_W'(DIV_STEPS - 1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_obs_zero ? ST_FIN : ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = ST_SQ0;
      end
      ST_SQ0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LL;
        state_nxt   = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LH;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HH;
        cmd.acc_op  = ACC_MID;
        state_nxt   = ST_SQ3;
      end
      ST_SQ3: begin
        cmd.acc_op = ACC_HIGH;
        state_nxt  = ST_CHK;
      end
      ST_CHK: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = stat.sq_ovf ? ST_ACC : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (div_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.last) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TFCSA_ASSERT_IMPL(a_emit_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_FIN))
  `TFCSA_ASSERT_NEXT(a_chk_branch, clk, rst_n, state_r == ST_CHK, state_r == ST_DIV || state_r == ST_ACC)
  `TFCSA_ASSERT_NEXT(a_div_ends, clk, rst_n, state_r == ST_DIV && div_last, state_r == ST_ACC)

endmodule

>>> design/template_fit_chi_square_accumulator_unit.sv
// Top level of the template-fit chi-square accumulator.
// Depends on tfcsa_pkg, tfcsa_regs, tfcsa_ctrl and tfcsa_dpath.
//
// Each input transfer carries one histogram bin: an observed count O, a fixed
// background B and two template contents T1 and T2, all with FRAC_BITS fraction
// bits. The unit forms E = B + s1*T1 + s2*T2 with the scale factors from the
// configuration registers and, for a nonzero O, adds the Neyman term
// (O - E)^2 / O, truncated to a Q48.16 value, to a saturating 64-bit sum. Bins
// with a zero count add nothing. On a bin with last_bin set the unit presents
// the sum and a saturation flag as one output transfer and starts a new sum.
// A bin with a nonzero count passes through setup, squaring on one shared
// 27x27 multiplier, the radix-4 divider, which builds a 64-bit quotient two
// bits per step, and bookkeeping before the next bin is accepted; a zero-count
// bin goes straight to bookkeeping, and a bin whose term is too large for 64
// bits skips the divider. The output sits in its own register, so new bins are
// accepted while a finished sum waits to be taken; only a second last_bin waits
// for that register to drain. Configuration writes belong to idle periods.
module template_fit_chi_square_accumulator_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tfcsa_pkg::APB_AW-1:0]        cfg_paddr,
  input  logic [tfcsa_pkg::APB_DW-1:0]        cfg_pwdata,
  output logic [tfcsa_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                                cfg_pready,
  // Bin input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tfcsa_pkg::OBS_W-1:0]         in_observed_count,
  input  logic signed [tfcsa_pkg::BIN_W-1:0]  in_fixed_background,
  input  logic signed [tfcsa_pkg::BIN_W-1:0]  in_first_template,
  input  logic signed [tfcsa_pkg::BIN_W-1:0]  in_second_template,
  input  logic                                in_last_bin,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tfcsa_pkg::SUM_W-1:0]         out_chi_square_sum,
  output logic                                out_saturated
);
  import tfcsa_pkg::*;

  logic [SCALE_W-1:0] scale_first;
  logic [SCALE_W-1:0] scale_second;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  // Scale factors are plain registers on the configuration port; reads return
  // the stored 20-bit value, zero extended.
  tfcsa_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .scale_first  (scale_first),
    .scale_second (scale_second)
  );

  // The controller owns both handshakes and walks each bin through the
  // datapath one step per state.
  tfcsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath keeps the expected value exact with FRAC_BITS+16 fraction
  // bits, squares the difference and divides by the count scaled to match,
  // so the quotient is already the Q48.16 term.
  tfcsa_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .scale_first         (scale_first),
    .scale_second        (scale_second),
    .in_observed_count   (in_observed_count),
    .in_fixed_background (in_fixed_background),
    .in_first_template   (in_first_template),
    .in_second_template  (in_second_template),
    .in_last_bin         (in_last_bin),
    .cmd                 (cmd),
    .stat                (stat),
    .out_chi_square_sum  (out_chi_square_sum),
    .out_saturated       (out_saturated)
  );

endmodule
